// ===== sv/arp_pkg.sv =====
package arp_pkg;

    localparam int unsigned FRAME_BYTES = 42;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 8'd1;

    localparam logic [POS_W-1:0] POS_LAST = 6'd41;
    localparam logic [7:0] OPER_REPLY_LO = 8'h02;

    typedef enum logic
    {
        ST_RX,
        ST_TX
    } arp_state_t;

    typedef struct packed
    {
        logic rx_take;
        logic tx_start;
        logic tx_adv;
    } arp_cmd_t;

    typedef struct packed
    {
        logic frame_ok;
        logic tx_final;
    } arp_status_t;

    // expected header bytes 12..21 of a request
    function automatic logic [7:0] req_hdr_byte(input logic [3:0] k);
        logic [7:0] b;
        unique case (k)
            4'd0:    b = 8'h08;
            4'd1:    b = 8'h06;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h08;
            4'd5:    b = 8'h00;
            4'd6:    b = 8'h06;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h00;
            4'd9:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // byte k of a 48-bit address, most significant first
    function automatic logic [7:0] mac_byte(input logic [47:0] v, input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = v[47:40];
            3'd1:    b = v[39:32];
            3'd2:    b = v[31:24];
            3'd3:    b = v[23:16];
            3'd4:    b = v[15:8];
            3'd5:    b = v[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // byte k of a 32-bit address, most significant first
    function automatic logic [7:0] ip_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== sv/arp_ctrl.sv =====
module arp_ctrl
    import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_last,
    input  logic        tx_ready,
    input  arp_status_t status,
    output logic        rx_ready,
    output logic        tx_valid,
    output arp_cmd_t    cmd
);

    arp_state_t state_reg;
    arp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        rx_ready     = 1'b0;
        tx_valid     = 1'b0;
        cmd.rx_take  = 1'b0;
        cmd.tx_start = 1'b0;
        cmd.tx_adv   = 1'b0;
        unique case (state_reg)
            ST_RX:
            begin
                rx_ready    = 1'b1;
                cmd.rx_take = rx_valid;
                if (rx_valid && rx_last && status.frame_ok)
                begin
                    cmd.tx_start = 1'b1;
                    state_next   = ST_TX;
                end
            end
            ST_TX:
            begin
                tx_valid = 1'b1;
                if (tx_ready)
                begin
                    if (status.tx_final)
                    begin
                        state_next = ST_RX;
                    end
                    else
                    begin
                        cmd.tx_adv = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

endmodule

// ===== sv/arp_dp.sv =====
module arp_dp
    import arp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  arp_cmd_t              cmd,
    input  logic [7:0]            rx_byte,
    input  logic                  rx_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output arp_status_t           status,
    output logic [7:0]            tx_byte,
    output logic                  tx_last
);

    logic [47:0]      own_mac_reg;
    logic [31:0]      own_ip_reg;
    logic [47:0]      req_mac_reg;
    logic [47:0]      sha_reg;
    logic [31:0]      spa_reg;
    logic [POS_W-1:0] count_reg;
    logic             ok_reg;
    logic [POS_W-1:0] tx_pos_reg;

    logic [POS_W-1:0] count_next;
    logic             ok_next;
    logic             in_frame;
    logic             mismatch;
    logic [POS_W-1:0] rx_off;
    logic [POS_W-1:0] tx_off;

    assign in_frame = (count_reg < POS_W'(FRAME_BYTES));
    assign rx_off   = count_reg - 6'd38;

    always_comb
    begin
        mismatch = 1'b0;
        if (in_frame)
        begin
            if (count_reg >= 6'd12 && count_reg < 6'd22)
            begin
                mismatch = (rx_byte != req_hdr_byte(4'(count_reg - 6'd12)));
            end
            else if (count_reg >= 6'd38)
            begin
                mismatch = (rx_byte != ip_byte(own_ip_reg, rx_off[1:0]));
            end
        end
    end

    assign count_next      = in_frame ? count_reg + 6'd1 : count_reg;
    assign ok_next         = ok_reg & ~mismatch;
    assign status.frame_ok = (count_next >= POS_W'(FRAME_BYTES)) && ok_next;
    assign status.tx_final = (tx_pos_reg == POS_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
            req_mac_reg <= '0;
            sha_reg     <= '0;
            spa_reg     <= '0;
            count_reg   <= '0;
            ok_reg      <= 1'b1;
            tx_pos_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[31:0];
            end
            if (cmd.rx_take)
            begin
                if (in_frame)
                begin
                    if (count_reg >= 6'd6 && count_reg < 6'd12)
                    begin
                        req_mac_reg <= {req_mac_reg[39:0], rx_byte};
                    end
                    else if (count_reg >= 6'd22 && count_reg < 6'd28)
                    begin
                        sha_reg <= {sha_reg[39:0], rx_byte};
                    end
                    else if (count_reg >= 6'd28 && count_reg < 6'd32)
                    begin
                        spa_reg <= {spa_reg[23:0], rx_byte};
                    end
                end
                if (rx_last)
                begin
                    count_reg <= '0;
                    ok_reg    <= 1'b1;
                end
                else
                begin
                    count_reg <= count_next;
                    ok_reg    <= ok_next;
                end
            end
            if (cmd.tx_start)
            begin
                tx_pos_reg <= '0;
            end
            else if (cmd.tx_adv)
            begin
                tx_pos_reg <= tx_pos_reg + 6'd1;
            end
        end
    end

    // reply byte mux
    always_comb
    begin
        tx_off = '0;
        priority if (tx_pos_reg < 6'd6)
        begin
            tx_byte = mac_byte(req_mac_reg, tx_pos_reg[2:0]);
        end
        else if (tx_pos_reg < 6'd12)
        begin
            tx_off  = tx_pos_reg - 6'd6;
            tx_byte = mac_byte(own_mac_reg, tx_off[2:0]);
        end
        else if (tx_pos_reg < 6'd20)
        begin
            tx_off  = tx_pos_reg - 6'd12;
            tx_byte = req_hdr_byte(tx_off[3:0]);
        end
        else if (tx_pos_reg == 6'd20)
        begin
            tx_byte = 8'h00;
        end
        else if (tx_pos_reg == 6'd21)
        begin
            tx_byte = OPER_REPLY_LO;
        end
        else if (tx_pos_reg < 6'd28)
        begin
            tx_off  = tx_pos_reg - 6'd22;
            tx_byte = mac_byte(own_mac_reg, tx_off[2:0]);
        end
        else if (tx_pos_reg < 6'd32)
        begin
            tx_off  = tx_pos_reg - 6'd28;
            tx_byte = ip_byte(own_ip_reg, tx_off[1:0]);
        end
        else if (tx_pos_reg < 6'd38)
        begin
            tx_off  = tx_pos_reg - 6'd32;
            tx_byte = mac_byte(sha_reg, tx_off[2:0]);
        end
        else
        begin
            tx_off  = tx_pos_reg - 6'd38;
            tx_byte = ip_byte(spa_reg, tx_off[1:0]);
        end
    end

    assign tx_last = status.tx_final;

endmodule

// ===== sv/arp_request_responder_unit.sv =====
// the first reply byte is offered the cycle after the last byte of a
// qualifying frame is accepted; the reply is 42 bytes long
// throughput: one received byte per cycle; no bytes are taken while a reply is sent
// reset (rst_n low, asynchronous) clears addresses and counters, own_mac and own_ip to 0
module arp_request_responder_unit
    import arp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // tx_byte
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    arp_cmd_t    cmd;
    arp_status_t status;

    assign cfg_ready = 1'b1;

    arp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (s_tvalid),
        .rx_last  (s_tlast),
        .tx_ready (m_tready),
        .status   (status),
        .rx_ready (s_tready),
        .tx_valid (m_tvalid),
        .cmd      (cmd)
    );

    arp_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rx_byte   (s_tdata),
        .rx_last   (s_tlast),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .tx_byte   (m_tdata),
        .tx_last   (m_tlast)
    );

endmodule
